>>> src/zfp_pkg.sv
`timescale 1ns / 1ps
package zfp_pkg;

    localparam int NUM_SENSORS = 4;
    localparam int NUM_REGS    = NUM_SENSORS + 1;
    localparam int ADDR_W      = $clog2(NUM_REGS) + 2;
    localparam int IDX_W       = $clog2(NUM_REGS);
    localparam int FORCE_W     = 16;
    localparam int POS_W       = 16;
    localparam int PROD_W      = FORCE_W + POS_W;
    localparam int SUM_W       = PROD_W + $clog2(NUM_SENSORS) + 1;
    localparam int TOTAL_W     = 18;
    localparam int THRESH_W    = 17;
    localparam int NUM_MAG_W   = SUM_W - 1;
    localparam int QUOT_W      = 17;
    localparam int COORD_W     = 16;
    localparam int FRONT_STAGES = 3;
    localparam int PIPE_STAGES  = FRONT_STAGES + QUOT_W + 1;

    typedef enum logic [IDX_W-1:0] {
        REG_THRESHOLD = IDX_W'(0),
        REG_POS_0     = IDX_W'(1)
    } reg_idx_t;

    typedef struct packed {
        logic [THRESH_W-1:0]                threshold;
        logic [NUM_SENSORS-1:0][2*POS_W-1:0] pos;
    } cfg_t;

    typedef struct packed {
        logic                      contact;
        logic                      ovf_x;
        logic                      ovf_y;
        logic                      neg_x;
        logic                      neg_y;
        logic signed [TOTAL_W-1:0] total;
    } meta_t;

    function automatic logic [COORD_W-1:0] sat_coord(
        input logic              contact,
        input logic              ovf,
        input logic              neg,
        input logic [QUOT_W-1:0] q
    );
        logic [QUOT_W-1:0] nq;
        logic [COORD_W-1:0] res;
        nq = QUOT_W'(0) - q;
        if (!contact)
            res = '0;
        else if (neg)
            res = (ovf || q > QUOT_W'(32768)) ? 16'h8000 : nq[COORD_W-1:0];
        else
            res = (ovf || q > QUOT_W'(32767)) ? 16'h7FFF : q[COORD_W-1:0];
        return res;
    endfunction

endpackage

>>> src/zfp_if.sv
`timescale 1ns / 1ps
interface zfp_in_if;
    import zfp_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [FORCE_W-1:0] force_0;
    logic signed [FORCE_W-1:0] force_1;
    logic signed [FORCE_W-1:0] force_2;
    logic signed [FORCE_W-1:0] force_3;
    modport source(output valid, force_0, force_1, force_2, force_3, input ready);
    modport sink(input valid, force_0, force_1, force_2, force_3, output ready);
endinterface

interface zfp_out_if;
    import zfp_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] zmp_x;
    logic signed [COORD_W-1:0] zmp_y;
    logic signed [TOTAL_W-1:0] total_force;
    logic                      contact;
    modport source(output valid, zmp_x, zmp_y, total_force, contact, input ready);
    modport sink(input valid, zmp_x, zmp_y, total_force, contact, output ready);
endinterface

>>> src/zfp_regs.sv
`timescale 1ns / 1ps
module zfp_regs
    import zfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t             cfg_reg;
    logic [IDX_W-1:0] idx;
    logic             wr;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:2];
    assign wr     = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold <= THRESH_W'(1);
            cfg_reg.pos       <= '0;
        end
        else if (wr)
        begin
            if (idx == REG_THRESHOLD)
                cfg_reg.threshold <= pwdata[THRESH_W-1:0];
            for (int k = 0; k < NUM_SENSORS; k++)
                if (idx == IDX_W'(k + 1))
                    cfg_reg.pos[k] <= pwdata;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (idx == REG_THRESHOLD)
            prdata = 32'(cfg_reg.threshold);
        for (int k = 0; k < NUM_SENSORS; k++)
            if (idx == IDX_W'(k + 1))
                prdata = cfg_reg.pos[k];
    end

endmodule

>>> src/zfp_front.sv
`timescale 1ns / 1ps
module zfp_front
    import zfp_pkg::*;
(
    input  logic                                   clk,
    input  logic                                   en,
    input  cfg_t                                   cfg,
    input  logic [NUM_SENSORS-1:0][FORCE_W-1:0]    forces,
    output meta_t                                  meta,
    output logic [NUM_MAG_W-1:0]                   mag_x,
    output logic [NUM_MAG_W-1:0]                   mag_y,
    output logic [TOTAL_W-1:0]                     den
);

    // stage 1: products
    logic signed [PROD_W-1:0]  px_reg [NUM_SENSORS];
    logic signed [PROD_W-1:0]  py_reg [NUM_SENSORS];
    logic signed [FORCE_W-1:0] f_reg  [NUM_SENSORS];
    // stage 2: sums
    logic signed [SUM_W-1:0]   sx_reg, sx_next;
    logic signed [SUM_W-1:0]   sy_reg, sy_next;
    logic signed [TOTAL_W-1:0] tot_reg, tot_next;
    // stage 3: magnitudes and flags
    meta_t                     meta_reg, meta_next;
    logic [NUM_MAG_W-1:0]      mx_reg, mx_next, my_reg, my_next;
    logic [TOTAL_W-1:0]        den_reg, den_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NUM_SENSORS; k++)
            begin
                f_reg[k]  <= signed'(forces[k]);
                px_reg[k] <= signed'(forces[k]) * signed'(cfg.pos[k][POS_W-1:0]);
                py_reg[k] <= signed'(forces[k]) * signed'(cfg.pos[k][2*POS_W-1:POS_W]);
            end
            sx_reg   <= sx_next;
            sy_reg   <= sy_next;
            tot_reg  <= tot_next;
            meta_reg <= meta_next;
            mx_reg   <= mx_next;
            my_reg   <= my_next;
            den_reg  <= den_next;
        end
    end

    always_comb
    begin
        sx_next  = '0;
        sy_next  = '0;
        tot_next = '0;
        for (int k = 0; k < NUM_SENSORS; k++)
        begin
            sx_next  = sx_next + SUM_W'(px_reg[k]);
            sy_next  = sy_next + SUM_W'(py_reg[k]);
            tot_next = tot_next + TOTAL_W'(f_reg[k]);
        end
    end

    always_comb
    begin
        logic [SUM_W-1:0]   ax, ay;
        logic [TOTAL_W-1:0] ad;
        ax = sx_reg[SUM_W-1] ? SUM_W'(-sx_reg) : SUM_W'(sx_reg);
        ay = sy_reg[SUM_W-1] ? SUM_W'(-sy_reg) : SUM_W'(sy_reg);
        ad = tot_reg[TOTAL_W-1] ? TOTAL_W'(-tot_reg) : TOTAL_W'(tot_reg);
        mx_next  = ax[NUM_MAG_W-1:0];
        my_next  = ay[NUM_MAG_W-1:0];
        den_next = ad;
        meta_next.total   = tot_reg;
        meta_next.contact = (tot_reg != '0) && (ad >= TOTAL_W'(cfg.threshold));
        // quotient needs more than QUOT_W bits: saturates anyway
        meta_next.ovf_x = (NUM_MAG_W + 3)'(mx_next)
                          >= ((NUM_MAG_W + 3)'(ad) << QUOT_W);
        meta_next.ovf_y = (NUM_MAG_W + 3)'(my_next)
                          >= ((NUM_MAG_W + 3)'(ad) << QUOT_W);
        meta_next.neg_x = sx_reg[SUM_W-1] ^ tot_reg[TOTAL_W-1];
        meta_next.neg_y = sy_reg[SUM_W-1] ^ tot_reg[TOTAL_W-1];
    end

    assign meta  = meta_reg;
    assign mag_x = mx_reg;
    assign mag_y = my_reg;
    assign den   = den_reg;

endmodule

>>> src/zfp_div.sv
`timescale 1ns / 1ps
module zfp_div
    import zfp_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [NUM_MAG_W-1:0] num,
    input  logic [TOTAL_W-1:0]   den,
    output logic [QUOT_W-1:0]    quot
);

    localparam int TW = NUM_MAG_W + 2;

    logic [NUM_MAG_W-1:0] r_reg [QUOT_W];
    logic [QUOT_W-1:0]    q_reg [QUOT_W];
    logic [TOTAL_W-1:0]   d_reg [QUOT_W];

    // one restoring step per stage, quotient bit QUOT_W-1 first
    for (genvar j = 0; j < QUOT_W; j++)
    begin : g_step
        logic [NUM_MAG_W-1:0] r_prev, r_next;
        logic [QUOT_W-1:0]    q_prev, q_next;
        logic [TOTAL_W-1:0]   d_prev;
        logic [TW-1:0]        trial;

        if (j == 0)
        begin : g_first
            assign r_prev = num;
            assign q_prev = '0;
            assign d_prev = den;
        end
        else
        begin : g_rest
            assign r_prev = r_reg[j-1];
            assign q_prev = q_reg[j-1];
            assign d_prev = d_reg[j-1];
        end

        always_comb
        begin
            trial  = TW'(r_prev) - (TW'(d_prev) << (QUOT_W - 1 - j));
            r_next = trial[TW-1] ? r_prev : trial[NUM_MAG_W-1:0];
            q_next = q_prev;
            q_next[QUOT_W-1-j] = !trial[TW-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[j] <= r_next;
                q_reg[j] <= q_next;
                d_reg[j] <= d_prev;
            end
        end
    end

    assign quot = q_reg[QUOT_W-1];

endmodule

>>> src/zmp_from_pressure_array_unit.sv
`timescale 1ns / 1ps
// Center of pressure of a four-sensor foot array. Accepts one force sample per
// clock while the pipe is not held and returns zmp_x/zmp_y (force-weighted
// sensor positions divided by the total, truncated toward zero and saturated),
// the total force and a contact flag, via multiply, sum and magnitude stages,
// a 17-stage restoring divider (one quotient bit per stage, one for each
// coordinate) and the output register. The whole pipe holds when the output
// register is full and not taken. The user writes sensor positions and the
// threshold over the APB port only while the block is idle (not enforced).
module zmp_from_pressure_array_unit
    import zfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    zfp_in_if.sink            sample,
    zfp_out_if.source         result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t                              cfg;
    logic                              en;
    logic [PIPE_STAGES-1:0]            v_reg, v_next;
    logic [NUM_SENSORS-1:0][FORCE_W-1:0] forces;
    meta_t                             meta_f;
    meta_t                             meta_reg [QUOT_W];
    logic [NUM_MAG_W-1:0]              mag_x, mag_y;
    logic [TOTAL_W-1:0]                den;
    logic [QUOT_W-1:0]                 qx, qy;
    logic [COORD_W-1:0]                zx_reg, zy_reg;
    logic [TOTAL_W-1:0]                tot_reg;
    logic                              con_reg;
    meta_t                             m_last;

    zfp_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
    );

    assign forces[0] = sample.force_0;
    assign forces[1] = sample.force_1;
    assign forces[2] = sample.force_2;
    assign forces[3] = sample.force_3;

    // advance everything unless the output item is stuck
    assign en           = !v_reg[PIPE_STAGES-1] || result.ready;
    assign sample.ready = en;

    zfp_front u_front (
        .clk(clk), .en(en), .cfg(cfg), .forces(forces),
        .meta(meta_f), .mag_x(mag_x), .mag_y(mag_y), .den(den)
    );

    zfp_div u_div_x (.clk(clk), .en(en), .num(mag_x), .den(den), .quot(qx));
    zfp_div u_div_y (.clk(clk), .en(en), .num(mag_y), .den(den), .quot(qy));

    assign v_next = {v_reg[PIPE_STAGES-2:0], sample.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= v_next;
    end

    // carry flags alongside the divider
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta_reg[0] <= meta_f;
            for (int j = 1; j < QUOT_W; j++)
                meta_reg[j] <= meta_reg[j-1];
            zx_reg  <= sat_coord(m_last.contact, m_last.ovf_x, m_last.neg_x, qx);
            zy_reg  <= sat_coord(m_last.contact, m_last.ovf_y, m_last.neg_y, qy);
            tot_reg <= m_last.total;
            con_reg <= m_last.contact;
        end
    end

    assign m_last = meta_reg[QUOT_W-1];

    assign result.valid       = v_reg[PIPE_STAGES-1];
    assign result.zmp_x       = zx_reg;
    assign result.zmp_y       = zy_reg;
    assign result.total_force = tot_reg;
    assign result.contact     = con_reg;

    a_nocontact_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.contact |-> result.zmp_x == '0 && result.zmp_y == '0)
        else $error("coordinates nonzero without contact");

    a_contact_total: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.contact |-> result.total_force != '0)
        else $error("contact with zero total");

    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> result.valid && $stable(result.zmp_x)
                                         && $stable(result.total_force))
        else $error("stalled item lost");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        sample.ready == (!result.valid || result.ready))
        else $error("input ready mismatch");

endmodule
